// ===== design/ccbd_pkg.sv =====
// ----------------------------------------------------------------------------
// Console CPU bus decoder package
// Shared types and constants for the decoder controller and datapath.
// ----------------------------------------------------------------------------
package ccbd_pkg;

	localparam int RAM_BYTES  = 2048;
	localparam int SRAM_BYTES = 8192;
	localparam int RAM_AW     = $clog2(RAM_BYTES);
	localparam int SRAM_AW    = $clog2(SRAM_BYTES);
	localparam int PPU_REGS   = 8;
	localparam int APU_REGS   = 32;
	localparam int PPU_AW     = $clog2(PPU_REGS);
	localparam int APU_AW     = $clog2(APU_REGS);

	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 16;

	localparam logic [15:0] ADDR_EXP_BASE = 16'h4020;
	localparam logic [15:0] ADDR_PRG_BASE = 16'h8000;
	localparam logic [15:0] ADDR_PRG_HI   = 16'hC000;

	localparam logic [1:0] PRG_BANKS_RESET = 2'd2;
	localparam logic [1:0] PRG_MIRROR      = 2'd1;

	typedef enum logic [2:0] {
		RGN_RAM  = 3'd0,
		RGN_PPU  = 3'd1,
		RGN_APU  = 3'd2,
		RGN_EXP  = 3'd3,
		RGN_SRAM = 3'd4,
		RGN_PRG  = 3'd5
	} region_t;

	typedef enum logic [3:0] {
		ST_CLEAR = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_HI    = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	typedef struct packed {
		logic clear;
		logic issue0;
		logic issue1;
		logic cap_lo;
		logic load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic clear_last;
		logic in_word;
	} dp_stat_t;

endpackage

// ===== design/ccbd_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write or read per cycle at one address, with registered read data.
// ----------------------------------------------------------------------------
module ccbd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

// ===== design/ccbd_ctrl.sv =====
// ----------------------------------------------------------------------------
// Bus decoder controller
// Sequences the reset clearing pass and the one or two byte accesses of each
// transfer, and owns the handshakes of both stream sides.
// ----------------------------------------------------------------------------
module ccbd_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	output logic                m_tvalid,
	input  logic                m_tready,
	output ccbd_pkg::ctrl_cmd_t cmd,
	input  ccbd_pkg::dp_stat_t  stat
);
	import ccbd_pkg::*;

	state_t state_q;
	state_t state_nxt;
	logic   m_tvalid_q;
	logic   out_free;
	logic   accept;

	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE) && out_free;
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;

	always_comb begin
		cmd          = '0;
		cmd.clear    = (state_q == ST_CLEAR);
		cmd.issue0   = accept;
		cmd.issue1   = (state_q == ST_HI);
		cmd.cap_lo   = (state_q == ST_HI);
		cmd.load_out = (state_q == ST_DONE);
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (stat.clear_last) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					state_nxt = stat.in_word ? ST_HI : ST_DONE;
				end
			end
			ST_HI: begin
				state_nxt = ST_DONE;
			end
			ST_DONE: begin
				state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== design/ccbd_dp.sv =====
// ----------------------------------------------------------------------------
// Bus decoder datapath
// Address decode, the byte access port onto all stores, byte assembly and the
// result register.
// ----------------------------------------------------------------------------
module ccbd_dp #(
	parameter int PRG_BYTES = 32768
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wen,
	input  logic [1:0]                          cfg_wdata,
	input  logic [ccbd_pkg::IN_TDATA_W-1:0]     s_tdata,
	output logic [ccbd_pkg::OUT_TDATA_W-1:0]    m_tdata,
	input  ccbd_pkg::ctrl_cmd_t                 cmd,
	output ccbd_pkg::dp_stat_t                  stat
);
	import ccbd_pkg::*;

	localparam int          PRG_AW   = $clog2(PRG_BYTES);
	localparam logic [15:0] PRG_SIZE = 16'(PRG_BYTES);

	logic [1:0]         in_func;
	logic [15:0]        in_addr;
	logic [15:0]        in_wdata;

	logic [1:0]         func_q;
	logic [15:0]        addr_q;
	logic [15:0]        wdata_q;
	logic [7:0]         lo_q;
	logic [15:0]        out_q;
	region_t            region_q;
	logic [7:0]         reg_rd_q;
	logic [7:0]         ppu_q [PPU_REGS];
	logic [7:0]         apu_q [APU_REGS];
	logic [SRAM_AW-1:0] clr_cnt_q;
	logic [1:0]         prg_banks_q;

	logic               acc_en;
	logic [15:0]        acc_addr;
	logic               acc_wr;
	logic [7:0]         acc_byte;
	region_t            acc_region;
	logic [15:0]        prg_off;
	logic [15:0]        prg_idx;

	logic               ram_we;
	logic [RAM_AW-1:0]  ram_addr;
	logic [7:0]         ram_wdata;
	logic [7:0]         ram_rdata;
	logic               sram_we;
	logic [SRAM_AW-1:0] sram_addr;
	logic [7:0]         sram_wdata;
	logic [7:0]         sram_rdata;
	logic               prg_we;
	logic [7:0]         prg_rdata;
	logic [7:0]         rbyte;

	function automatic region_t decode(input logic [15:0] a);
		region_t r;
		case (a[15:13])
			3'b000:  r = RGN_RAM;
			3'b001:  r = RGN_PPU;
			3'b010:  r = (a < ADDR_EXP_BASE) ? RGN_APU : RGN_EXP;
			3'b011:  r = RGN_SRAM;
			default: r = RGN_PRG;
		endcase
		return r;
	endfunction

	assign in_func  = s_tdata[1:0];
	assign in_addr  = s_tdata[17:2];
	assign in_wdata = s_tdata[33:18];

	assign stat.clear_last = (clr_cnt_q == '1);
	assign stat.in_word    = in_func[1];

	assign acc_en     = cmd.issue0 || cmd.issue1;
	assign acc_addr   = cmd.issue0 ? in_addr : addr_q + 16'd1;
	assign acc_wr     = cmd.issue0 ? in_func[0] : func_q[0];
	assign acc_byte   = cmd.issue0 ? in_wdata[7:0] : wdata_q[15:8];
	assign acc_region = decode(acc_addr);

	// Reads in the upper bank mirror the lower one when a single bank is fitted.
	always_comb begin
		if (!acc_wr && prg_banks_q == PRG_MIRROR && acc_addr >= ADDR_PRG_HI) begin
			prg_off = acc_addr - ADDR_PRG_HI;
		end else begin
			prg_off = acc_addr - ADDR_PRG_BASE;
		end
		prg_idx = (prg_off >= PRG_SIZE) ? prg_off - PRG_SIZE : prg_off;
	end

	assign ram_we     = cmd.clear || (acc_en && acc_wr && acc_region == RGN_RAM);
	assign ram_addr   = cmd.clear ? clr_cnt_q[RAM_AW-1:0] : acc_addr[RAM_AW-1:0];
	assign ram_wdata  = cmd.clear ? 8'h00 : acc_byte;
	assign sram_we    = cmd.clear || (acc_en && acc_wr && acc_region == RGN_SRAM);
	assign sram_addr  = cmd.clear ? clr_cnt_q : acc_addr[SRAM_AW-1:0];
	assign sram_wdata = cmd.clear ? 8'h00 : acc_byte;
	assign prg_we     = acc_en && acc_wr && acc_region == RGN_PRG;

	ccbd_ram #(.WIDTH(8), .DEPTH(RAM_BYTES)) u_work_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	ccbd_ram #(.WIDTH(8), .DEPTH(SRAM_BYTES)) u_save_ram (
		.clk   (clk),
		.we    (sram_we),
		.addr  (sram_addr),
		.wdata (sram_wdata),
		.rdata (sram_rdata)
	);

	ccbd_ram #(.WIDTH(8), .DEPTH(PRG_BYTES)) u_prg_mem (
		.clk   (clk),
		.we    (prg_we),
		.addr  (prg_idx[PRG_AW-1:0]),
		.wdata (acc_byte),
		.rdata (prg_rdata)
	);

	always_comb begin
		case (region_q)
			RGN_RAM:  rbyte = ram_rdata;
			RGN_PPU:  rbyte = reg_rd_q;
			RGN_APU:  rbyte = reg_rd_q;
			RGN_SRAM: rbyte = sram_rdata;
			RGN_PRG:  rbyte = prg_rdata;
			default:  rbyte = 8'h00;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q   <= '0;
			prg_banks_q <= PRG_BANKS_RESET;
			for (int i = 0; i < PPU_REGS; i++) begin
				ppu_q[i] <= 8'h00;
			end
			for (int i = 0; i < APU_REGS; i++) begin
				apu_q[i] <= 8'h00;
			end
		end else begin
			if (cmd.clear) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			if (cfg_wen) begin
				prg_banks_q <= cfg_wdata;
			end
			if (acc_en && acc_wr && acc_region == RGN_PPU) begin
				ppu_q[acc_addr[PPU_AW-1:0]] <= acc_byte;
			end
			if (acc_en && acc_wr && acc_region == RGN_APU) begin
				apu_q[acc_addr[APU_AW-1:0]] <= acc_byte;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue0) begin
			func_q  <= in_func;
			addr_q  <= in_addr;
			wdata_q <= in_wdata;
		end
		if (acc_en) begin
			region_q <= acc_region;
			reg_rd_q <= (acc_region == RGN_PPU) ? ppu_q[acc_addr[PPU_AW-1:0]]
			                                    : apu_q[acc_addr[APU_AW-1:0]];
		end
		if (cmd.cap_lo) begin
			lo_q <= rbyte;
		end
		if (cmd.load_out) begin
			if (func_q[0]) begin
				out_q <= 16'h0000;
			end else if (func_q[1]) begin
				out_q <= {rbyte, lo_q};
			end else begin
				out_q <= {8'h00, rbyte};
			end
		end
	end

	assign m_tdata = out_q;

endmodule

// ===== design/console_cpu_bus_decoder_core.sv =====
// ----------------------------------------------------------------------------
// Console CPU bus decoder
// Maps byte and word accesses of a 16-bit CPU bus onto work RAM, PPU and APU
// registers, save RAM and program memory.
// ----------------------------------------------------------------------------
// Every store is reached through a single byte access port with registered
// read data, so the two bytes of a word go through it one after the other.
// A byte transfer passes from idle through the done state, and a word transfer
// through the high-byte state and then the done state. The result is loaded
// into the output register in the done state and is valid once the block is
// back in idle. The next transfer can be accepted there, but only once the
// previous result leaves or is leaving the output, so a result that waits on
// the output stalls the input. After reset the block clears work RAM and save
// RAM and accepts no transfer during that time; the bank register may be
// written at any time the block is idle.
module console_cpu_bus_decoder_core #(
	parameter int PRG_BYTES = 32768
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [1:0]  cfg_wdata,    // prg_banks
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,      // func[1:0], address[17:2], write_data[33:18]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata       // read_data[15:0]
);
	import ccbd_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	ccbd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.stat     (stat)
	);

	ccbd_dp #(.PRG_BYTES(PRG_BYTES)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.s_tdata   (s_tdata),
		.m_tdata   (m_tdata),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule

// ===== bench/console_cpu_bus_decoder_core_test.sv =====
// ----------------------------------------------------------------------------
// Console CPU bus decoder testbench
// Drives byte and word bus transfers into the decoder and checks every read
// result against a predictor that keeps its own copy of every store. A short
// directed part covers reset contents, region boundaries and the bank codes;
// random traffic under every bank setting follows, with bursts of idling on
// both sides, one long output stall and a final stretch at full rate.
// ----------------------------------------------------------------------------
module console_cpu_bus_decoder_core_test;
	import ccbd_pkg::*;

	localparam logic [15:0] ADDR_PPU_BASE  = 16'h2000;
	localparam logic [15:0] ADDR_APU_BASE  = 16'h4000;
	localparam logic [15:0] ADDR_SRAM_BASE = 16'h6000;
	localparam int          PRG_SIZE       = 32768;
	localparam int          IDLE_LIMIT     = 50000;
	localparam int          HOLD_CYCLES    = 300;
	localparam int          SETTLE_CYCLES  = 6;

	localparam logic [15:0] BOUNDARY_ADDRS [12] = '{
		16'h0000, 16'h1FFF, 16'h3FFF, 16'h4000, 16'h401F, 16'h5FFF,
		16'h6000, 16'h7FFF, 16'h8000, 16'hBFFF, 16'hC000, 16'hFFFF
	};

	typedef enum logic [1:0] {
		OP_READ_BYTE  = 2'd0,
		OP_WRITE_BYTE = 2'd1,
		OP_READ_WORD  = 2'd2,
		OP_WRITE_WORD = 2'd3
	} bus_op_t;

	typedef struct packed {
		bus_op_t     op;
		logic [15:0] addr;
		logic [15:0] data;
	} bus_access_t;

	typedef struct packed {
		bus_op_t     op;
		logic [15:0] addr;
		logic [15:0] read_data;
	} read_result_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        cfg_wen = 1'b0;
	logic [1:0]  cfg_wdata = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;

	logic [7:0] work_ram [RAM_BYTES];
	logic [7:0] ppu_regs [PPU_REGS];
	logic [7:0] apu_regs [APU_REGS];
	logic [7:0] save_ram [SRAM_BYTES];
	logic [7:0] program_mem [PRG_SIZE];
	bit         program_valid [PRG_SIZE];
	logic [1:0] prg_banks = PRG_BANKS_RESET;

	read_result_t expected_reads [$];
	int           mismatch_count = 0;
	int           idle_cycles = 0;
	bit           sender_idling = 1'b1;
	bit           receiver_idling = 1'b1;
	bit           hold_request = 1'b0;

	console_cpu_bus_decoder_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic region_t region_of(input logic [15:0] a);
		if (a < ADDR_PPU_BASE) return RGN_RAM;
		if (a < ADDR_APU_BASE) return RGN_PPU;
		if (a < ADDR_EXP_BASE) return RGN_APU;
		if (a < ADDR_SRAM_BASE) return RGN_EXP;
		if (a < ADDR_PRG_BASE) return RGN_SRAM;
		return RGN_PRG;
	endfunction

	function automatic logic [14:0] prg_read_offset(input logic [15:0] a);
		logic [15:0] off;
		if (a >= ADDR_PRG_HI && prg_banks == PRG_MIRROR) begin
			off = a - ADDR_PRG_HI;
		end else begin
			off = a - ADDR_PRG_BASE;
		end
		return off[14:0];
	endfunction

	function automatic bit prg_readable(input logic [15:0] a);
		if (region_of(a) != RGN_PRG) return 1'b1;
		return program_valid[prg_read_offset(a)];
	endfunction

	function automatic logic [7:0] decoded_read(input logic [15:0] a);
		case (region_of(a))
			RGN_RAM:  return work_ram[a[RAM_AW-1:0]];
			RGN_PPU:  return ppu_regs[a[PPU_AW-1:0]];
			RGN_APU:  return apu_regs[a[APU_AW-1:0]];
			RGN_SRAM: return save_ram[a[SRAM_AW-1:0]];
			RGN_PRG:  return program_mem[prg_read_offset(a)];
			default:  return 8'h00;
		endcase
	endfunction

	function automatic void decoded_write(input logic [15:0] a, input logic [7:0] d);
		logic [15:0] off;
		off = a - ADDR_PRG_BASE;
		case (region_of(a))
			RGN_RAM:  work_ram[a[RAM_AW-1:0]] = d;
			RGN_PPU:  ppu_regs[a[PPU_AW-1:0]] = d;
			RGN_APU:  apu_regs[a[APU_AW-1:0]] = d;
			RGN_SRAM: save_ram[a[SRAM_AW-1:0]] = d;
			RGN_PRG: begin
				program_mem[off[14:0]] = d;
				program_valid[off[14:0]] = 1'b1;
			end
			default: ;
		endcase
	endfunction

	function automatic logic [15:0] predict_access(input bus_access_t acc);
		logic [15:0] next_addr;
		next_addr = acc.addr + 16'd1;
		case (acc.op)
			OP_READ_BYTE: return {8'h00, decoded_read(acc.addr)};
			OP_READ_WORD: return {decoded_read(next_addr), decoded_read(acc.addr)};
			OP_WRITE_BYTE: decoded_write(acc.addr, acc.data[7:0]);
			default: begin
				decoded_write(acc.addr, acc.data[7:0]);
				decoded_write(next_addr, acc.data[15:8]);
			end
		endcase
		return 16'h0000;
	endfunction

	function automatic bus_access_t random_access();
		bus_access_t acc;
		logic [15:0] base;
		acc.op = bus_op_t'($urandom_range(0, 3));
		acc.data = 16'($urandom);
		case ($urandom_range(0, 15))
			0, 1: acc.addr = 16'(($urandom_range(0, 3) << 11) | $urandom_range(0, 63));
			2: acc.addr = 16'($urandom_range(0, 16'h1FFF));
			3: acc.addr = 16'($urandom_range(ADDR_PPU_BASE, 16'h3FFF));
			4: acc.addr = 16'($urandom_range(ADDR_APU_BASE, 16'h401F));
			5: acc.addr = 16'($urandom_range(ADDR_EXP_BASE, 16'h5FFF));
			6: acc.addr = ADDR_SRAM_BASE + 16'($urandom_range(0, 1)) * 16'h1FC0
				+ 16'($urandom_range(0, 63));
			7: acc.addr = 16'($urandom_range(ADDR_SRAM_BASE, 16'h7FFF));
			8, 9, 10: begin
				case ($urandom_range(0, 3))
					0: base = 16'h8000;
					1: base = 16'hBFC0;
					2: base = 16'hC000;
					default: base = 16'hFFC0;
				endcase
				acc.addr = base + 16'($urandom_range(0, 63));
			end
			11: acc.addr = 16'($urandom_range(ADDR_PRG_BASE, 16'hFFFF));
			12: acc.addr = BOUNDARY_ADDRS[4'($urandom_range(0, 11))];
			default: acc.addr = 16'($urandom);
		endcase
		// Program memory that was never written must not be read; such reads
		// become writes of the same width.
		if (acc.op == OP_READ_BYTE && !prg_readable(acc.addr)) begin
			acc.op = OP_WRITE_BYTE;
		end else if (acc.op == OP_READ_WORD && !(prg_readable(acc.addr)
				&& prg_readable(acc.addr + 16'd1))) begin
			acc.op = OP_WRITE_WORD;
		end
		return acc;
	endfunction

	task automatic send_access(input bus_op_t op, input logic [15:0] addr,
			input logic [15:0] data);
		bus_access_t acc;
		acc = '{op: op, addr: addr, data: data};
		if (sender_idling && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {6'b0, data, addr, op};
		do @(negedge clk); while (!s_tready);
		expected_reads.push_back('{op: op, addr: addr, read_data: predict_access(acc)});
		@(posedge clk);
	endtask

	task automatic random_accesses(input int count);
		bus_access_t acc;
		repeat (count) begin
			acc = random_access();
			send_access(acc.op, acc.addr, acc.data);
		end
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (expected_reads.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_prg_banks(input logic [1:0] value);
		drain_results();
		cfg_wen <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_wen <= 1'b0;
		prg_banks = value;
	endtask

	task automatic test_reset_contents();
		send_access(OP_READ_WORD, 16'h0000, 16'hFFFF);
		send_access(OP_READ_WORD, 16'h2000, 16'hFFFF);
		send_access(OP_READ_WORD, 16'h401E, 16'hFFFF);
		send_access(OP_READ_WORD, 16'h4020, 16'hFFFF);
		send_access(OP_READ_WORD, 16'h6000, 16'hFFFF);
	endtask

	task automatic test_region_boundaries();
		send_access(OP_WRITE_WORD, 16'h1FFF, 16'h1A2B);
		send_access(OP_WRITE_WORD, 16'h3FFF, 16'h3C4D);
		send_access(OP_WRITE_WORD, 16'h401F, 16'h5E6F);
		send_access(OP_WRITE_WORD, 16'h5FFF, 16'h7081);
		send_access(OP_WRITE_WORD, 16'h7FFF, 16'h92A3);
		send_access(OP_WRITE_WORD, 16'hBFFF, 16'hB4C5);
		send_access(OP_WRITE_WORD, 16'hFFFF, 16'hD6E7);
		send_access(OP_WRITE_BYTE, 16'h0801, 16'hA5C3);
		send_access(OP_READ_WORD, 16'h1FFF, 16'h0000);
		send_access(OP_READ_WORD, 16'h3FFF, 16'h0000);
		send_access(OP_READ_WORD, 16'h401F, 16'h0000);
		send_access(OP_READ_WORD, 16'h5FFF, 16'h0000);
		send_access(OP_READ_WORD, 16'h7FFF, 16'h0000);
		send_access(OP_READ_WORD, 16'hFFFF, 16'h0000);
		send_access(OP_READ_BYTE, 16'h1801, 16'h0000);
		send_access(OP_READ_BYTE, 16'h2008, 16'h0000);
	endtask

	task automatic test_bank_codes();
		write_prg_banks(2'd1);
		send_access(OP_READ_WORD, 16'hBFFF, 16'h0000);
		write_prg_banks(2'd0);
		send_access(OP_READ_WORD, 16'hBFFF, 16'h0000);
		write_prg_banks(2'd3);
		send_access(OP_READ_WORD, 16'hBFFF, 16'h0000);
		write_prg_banks(2'd2);
		send_access(OP_READ_WORD, 16'hBFFF, 16'h0000);
	endtask

	task automatic test_random_per_bank_code();
		write_prg_banks(2'd1);
		random_accesses(200);
		write_prg_banks(2'd0);
		random_accesses(100);
		write_prg_banks(2'd3);
		random_accesses(100);
		write_prg_banks(2'd2);
		random_accesses(150);
	endtask

	task automatic test_output_stall();
		drain_results();
		sender_idling = 1'b0;
		hold_request = 1'b1;
		random_accesses(40);
		sender_idling = 1'b1;
	endtask

	task automatic test_full_rate();
		write_prg_banks(2'd1);
		sender_idling = 1'b0;
		receiver_idling = 1'b0;
		random_accesses(150);
	endtask

	initial begin
		foreach (work_ram[i]) work_ram[i] = 8'h00;
		foreach (ppu_regs[i]) ppu_regs[i] = 8'h00;
		foreach (apu_regs[i]) apu_regs[i] = 8'h00;
		foreach (save_ram[i]) save_ram[i] = 8'h00;
		foreach (program_mem[i]) begin
			program_mem[i] = 8'h00;
			program_valid[i] = 1'b0;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_contents();
		test_region_boundaries();
		test_bank_codes();
		test_random_per_bank_code();
		test_output_stall();
		test_full_rate();
		drain_results();
		if (mismatch_count == 0 && expected_reads.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_request) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
				m_tready <= 1'b1;
			end else if (receiver_idling && $urandom_range(0, 7) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	function automatic void record_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= 10) $display("%s", msg);
	endfunction

	always @(negedge clk) begin
		read_result_t want;
		if (m_tvalid && m_tready) begin
			if (expected_reads.size() == 0) begin
				record_mismatch($sformatf("unexpected result read_data=%h", m_tdata));
			end else begin
				want = expected_reads.pop_front();
				if (m_tdata !== want.read_data) begin
					record_mismatch($sformatf(
						"%s at %h: read_data expected %h, actual %h",
						want.op.name(), want.addr, want.read_data, m_tdata));
				end
			end
		end
	end

	always @(negedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule
